>>> src/triangle_barycentric_weights_macros.svh
// Assertion macros for the barycentric weight block.
// No dependencies; expects clk and arst_n in the including scope.
`ifndef TRIANGLE_BARYCENTRIC_WEIGHTS_MACROS_SVH
`define TRIANGLE_BARYCENTRIC_WEIGHTS_MACROS_SVH

// same-cycle implication, disabled during reset
`define TBW_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define TBW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/tbw_pkg.sv
// Shared widths, register codes and types of the barycentric weight block.
// No dependencies.
package tbw_pkg;

	localparam int FIELD_W    = 16;
	localparam int CRD_W      = FIELD_W + 1;
	localparam int DIFF_W     = CRD_W + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int CROSS_W    = 34;
	localparam int NUM_W      = CROSS_W - 1;
	localparam int WEIGHT_W   = 24;
	localparam int NUM_LANES  = 3;
	localparam int NUM_REGS   = 6;
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	localparam int COORD_WIDTH_DEF      = 16;
	localparam int WEIGHT_FRAC_BITS_DEF = 16;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_A_X = 3'd0,
		REG_A_Y = 3'd1,
		REG_B_X = 3'd2,
		REG_B_Y = 3'd3,
		REG_C_X = 3'd4,
		REG_C_Y = 3'd5
	} tbw_reg_t;

	typedef struct packed {
		logic valid;
		logic degen;
	} tbw_ctl_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight_a;
		logic [WEIGHT_W-1:0] weight_b;
		logic [WEIGHT_W-1:0] weight_c;
		logic                degenerate;
	} tbw_res_t;

endpackage

>>> src/tbw_div_pipe.sv
// Pipelined area-ratio divider: one quotient bit per stage, three lanes, shared divisor.
// Depends on tbw_pkg.
module tbw_div_pipe #(
	parameter int WEIGHT_FRAC_BITS = tbw_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 en,
	input  tbw_pkg::tbw_ctl_t                                    in_ctl,
	input  logic [tbw_pkg::NUM_LANES-1:0][tbw_pkg::NUM_W-1:0]    num,
	input  logic [tbw_pkg::NUM_W-1:0]                            den,
	output logic                                                 out_valid,
	output tbw_pkg::tbw_res_t                                    res
);

	localparam int QW       = tbw_pkg::WEIGHT_W;
	localparam int NW       = tbw_pkg::NUM_W;
	localparam int LN       = tbw_pkg::NUM_LANES;
	localparam int INT_BITS = QW - WEIGHT_FRAC_BITS;
	localparam int XW       = NW + QW;

	logic [LN-1:0][NW-1:0] rem_s [QW+1];
	logic [LN-1:0][QW-1:0] acc_s [QW+1];
	logic [LN-1:0]         sat_s [QW+1];
	logic [NW-1:0]         den_s [QW+1];
	tbw_pkg::tbw_ctl_t     ctl_s [QW+1];

	logic [LN-1:0][XW-1:0] x;
	logic [LN-1:0]         sat;

	always_comb begin
		for (int l = 0; l < LN; l++) begin
			x[l]   = {num[l], {QW{1'b0}}} >> INT_BITS;
			sat[l] = x[l][XW-1:QW] >= den;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LN; l++) begin
				rem_s[0][l] <= x[l][XW-1:QW];
				acc_s[0][l] <= x[l][QW-1:0];
			end
			sat_s[0] <= sat;
			den_s[0] <= den;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [LN-1:0][NW:0]   r2;
		logic [LN-1:0][NW+1:0] dif;
		logic [LN-1:0][NW-1:0] rem_d;
		logic [LN-1:0][QW-1:0] acc_d;

		always_comb begin
			for (int l = 0; l < LN; l++) begin
				r2[l]    = {rem_s[k][l], acc_s[k][l][QW-1]};
				dif[l]   = {1'b0, r2[l]} - {2'b00, den_s[k]};
				rem_d[l] = dif[l][NW+1] ? r2[l][NW-1:0] : dif[l][NW-1:0];
				acc_d[l] = {acc_s[k][l][QW-2:0], ~dif[l][NW+1]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= rem_d;
				acc_s[k+1] <= acc_d;
				sat_s[k+1] <= sat_s[k];
				den_s[k+1] <= den_s[k];
			end
		end
	end

	logic [LN-1:0][QW-1:0] w;

	always_comb begin
		for (int l = 0; l < LN; l++) begin
			if (ctl_s[QW].degen)
				w[l] = '0;
			else if (sat_s[QW][l])
				w[l] = '1;
			else
				w[l] = acc_s[QW][l];
		end
	end

	assign out_valid      = ctl_s[QW].valid;
	assign res.weight_a   = w[0];
	assign res.weight_b   = w[1];
	assign res.weight_c   = w[2];
	assign res.degenerate = ctl_s[QW].degen;

endmodule

>>> src/triangle_barycentric_weights.sv
// Barycentric weights of a query point against a triangle held in registers.
// Depends on tbw_pkg and tbw_div_pipe.
//
// Vertices A, B and C are written over the APB port (registers at byte
// addresses 0..20, one coordinate each, low 16 bits used); write them only
// while no item is in flight. Each input item is a point (point_x, point_y),
// taken when in_valid is high and in_stall low. Each result item carries
// weight_a/b/c (area of the opposite sub-triangle over the whole area,
// unsigned fixed point, truncated, saturated to all ones) and degenerate,
// set with all weights zero when the triangle has no area.
// The pipeline has 30 register stages. Four stages form the differences,
// products, cross products and magnitudes, then come a divider front stage
// and one stage per quotient bit (24), then the output register.
// Throughput is one item per cycle while in_stall is low.
// When out_stall holds the output, one more result lands in a skid register
// and in_stall then rises, freezing the pipeline until the output drains.
// Reset clears all valid bits and the vertex registers to zero.
module triangle_barycentric_weights #(
	parameter int COORD_WIDTH      = tbw_pkg::COORD_WIDTH_DEF,
	parameter int WEIGHT_FRAC_BITS = tbw_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tbw_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [tbw_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [tbw_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [tbw_pkg::FIELD_W-1:0] point_x,
	input  logic signed [tbw_pkg::FIELD_W-1:0] point_y,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tbw_pkg::WEIGHT_W-1:0]      weight_a,
	output logic [tbw_pkg::WEIGHT_W-1:0]      weight_b,
	output logic [tbw_pkg::WEIGHT_W-1:0]      weight_c,
	output logic                              degenerate
);

	localparam int FW = tbw_pkg::FIELD_W;
	localparam int CW = tbw_pkg::CRD_W;
	localparam int DW = tbw_pkg::DIFF_W;
	localparam int PW = tbw_pkg::PROD_W;
	localparam int XW = tbw_pkg::CROSS_W;
	localparam int NW = tbw_pkg::NUM_W;
	localparam int SW = (COORD_WIDTH > FW) ? FW : COORD_WIDTH;

	function automatic logic signed [CW-1:0] to_crd(input logic [FW-1:0] f);
		if (COORD_WIDTH > FW)
			to_crd = {1'b0, f};
		else
			to_crd = CW'(signed'(f[SW-1:0]));
	endfunction

	// configuration registers
	logic [FW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic [tbw_pkg::REG_IDX_W-1:0] reg_idx;
	logic cfg_wr;

	assign reg_idx = paddr[tbw_pkg::CFG_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0;
			ay_q <= '0;
			bx_q <= '0;
			by_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				tbw_pkg::REG_A_X: ax_q <= pwdata[FW-1:0];
				tbw_pkg::REG_A_Y: ay_q <= pwdata[FW-1:0];
				tbw_pkg::REG_B_X: bx_q <= pwdata[FW-1:0];
				tbw_pkg::REG_B_Y: by_q <= pwdata[FW-1:0];
				tbw_pkg::REG_C_X: cx_q <= pwdata[FW-1:0];
				tbw_pkg::REG_C_Y: cy_q <= pwdata[FW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tbw_pkg::REG_A_X: prdata = {{(tbw_pkg::CFG_DATA_W-FW){1'b0}}, ax_q};
			tbw_pkg::REG_A_Y: prdata = {{(tbw_pkg::CFG_DATA_W-FW){1'b0}}, ay_q};
			tbw_pkg::REG_B_X: prdata = {{(tbw_pkg::CFG_DATA_W-FW){1'b0}}, bx_q};
			tbw_pkg::REG_B_Y: prdata = {{(tbw_pkg::CFG_DATA_W-FW){1'b0}}, by_q};
			tbw_pkg::REG_C_X: prdata = {{(tbw_pkg::CFG_DATA_W-FW){1'b0}}, cx_q};
			tbw_pkg::REG_C_Y: prdata = {{(tbw_pkg::CFG_DATA_W-FW){1'b0}}, cy_q};
			default:          prdata = '0;
		endcase
	end

	// pipeline control
	logic skid_valid_q;
	logic adv;

	assign adv      = !skid_valid_q;
	assign in_stall = skid_valid_q;

	logic signed [CW-1:0] ax, ay, bx, by, cx, cy, px, py;

	assign ax = to_crd(ax_q);
	assign ay = to_crd(ay_q);
	assign bx = to_crd(bx_q);
	assign by = to_crd(by_q);
	assign cx = to_crd(cx_q);
	assign cy = to_crd(cy_q);
	assign px = to_crd(point_x);
	assign py = to_crd(point_y);

	logic valid_s1, valid_s2, valid_s3, valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage 1: coordinate differences
	logic signed [DW-1:0] apx_s1, apy_s1, bpx_s1, bpy_s1, cpx_s1, cpy_s1;
	logic signed [DW-1:0] bax_s1, bay_s1, cax_s1, cay_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			apx_s1 <= DW'(ax) - DW'(px);
			apy_s1 <= DW'(ay) - DW'(py);
			bpx_s1 <= DW'(bx) - DW'(px);
			bpy_s1 <= DW'(by) - DW'(py);
			cpx_s1 <= DW'(cx) - DW'(px);
			cpy_s1 <= DW'(cy) - DW'(py);
			bax_s1 <= DW'(bx) - DW'(ax);
			bay_s1 <= DW'(by) - DW'(ay);
			cax_s1 <= DW'(cx) - DW'(ax);
			cay_s1 <= DW'(cy) - DW'(ay);
		end
	end

	// stage 2: products, pairs per lane (a, b, c, total)
	logic signed [PW-1:0] prod_s2 [8];

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2[0] <= bpx_s1 * cpy_s1;
			prod_s2[1] <= bpy_s1 * cpx_s1;
			prod_s2[2] <= apx_s1 * cpy_s1;
			prod_s2[3] <= apy_s1 * cpx_s1;
			prod_s2[4] <= apx_s1 * bpy_s1;
			prod_s2[5] <= apy_s1 * bpx_s1;
			prod_s2[6] <= bax_s1 * cay_s1;
			prod_s2[7] <= bay_s1 * cax_s1;
		end
	end

	// stage 3: cross products
	logic signed [XW-1:0] cross_s3 [4];
	logic signed [PW-1:0] cross_d  [4];

	always_comb begin
		for (int l = 0; l < 4; l++)
			cross_d[l] = prod_s2[2*l] - prod_s2[2*l+1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 4; l++)
				cross_s3[l] <= cross_d[l][XW-1:0];
		end
	end

	// stage 4: magnitudes
	logic [tbw_pkg::NUM_LANES-1:0][NW-1:0] num_s4;
	logic [NW-1:0] den_s4;
	logic          degen_s4;
	logic [XW-1:0] mag_d [4];

	always_comb begin
		for (int l = 0; l < 4; l++)
			mag_d[l] = cross_s3[l][XW-1] ? -cross_s3[l] : cross_s3[l];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < tbw_pkg::NUM_LANES; l++)
				num_s4[l] <= mag_d[l][NW-1:0];
			den_s4   <= mag_d[3][NW-1:0];
			degen_s4 <= cross_s3[3] == '0;
		end
	end

	tbw_pkg::tbw_ctl_t div_ctl;
	tbw_pkg::tbw_res_t div_res;
	logic              div_valid;

	assign div_ctl.valid = valid_s4;
	assign div_ctl.degen = degen_s4;

	tbw_div_pipe #(
		.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_ctl   (div_ctl),
		.num      (num_s4),
		.den      (den_s4),
		.out_valid(div_valid),
		.res      (div_res)
	);

	// output register and skid
	tbw_pkg::tbw_res_t out_q, skid_q;
	logic              out_valid_q;
	logic              fin;

	assign fin = div_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!out_stall)
				skid_valid_q <= 1'b0;
		end else if (fin) begin
			if (out_valid_q && out_stall)
				skid_valid_q <= 1'b1;
			else
				out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!out_stall)
				out_q <= skid_q;
		end else if (fin) begin
			if (out_valid_q && out_stall)
				skid_q <= div_res;
			else
				out_q <= div_res;
		end
	end

	assign out_valid  = out_valid_q;
	assign weight_a   = out_q.weight_a;
	assign weight_b   = out_q.weight_b;
	assign weight_c   = out_q.weight_c;
	assign degenerate = out_q.degenerate;

endmodule

>>> src/tbw_checker.sv
// Port-level checks for the barycentric weight block, bound to its top level.
// Depends on tbw_pkg and triangle_barycentric_weights_macros.svh.
`include "triangle_barycentric_weights_macros.svh"

module tbw_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [tbw_pkg::WEIGHT_W-1:0]      weight_a,
	input logic [tbw_pkg::WEIGHT_W-1:0]      weight_b,
	input logic [tbw_pkg::WEIGHT_W-1:0]      weight_c,
	input logic                              degenerate
);

	`TBW_ASSERT_SAME(a_degen_zero, out_valid && degenerate, weight_a == '0 && weight_b == '0 && weight_c == '0, "degenerate item with nonzero weight")
	`TBW_ASSERT_SAME(a_stall_cause, in_stall, $past(out_valid && out_stall), "input stalled without a held output")
	`TBW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "output item dropped while stalled")
	`TBW_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(weight_a) && $stable(weight_b) && $stable(weight_c) && $stable(degenerate), "output item changed while stalled")

endmodule

bind triangle_barycentric_weights tbw_checker u_tbw_checker (.*);

>>> tb/sv/tb_triangle_barycentric_weights.sv
// Self-checking bench for triangle_barycentric_weights: directed and random triangles and points.
// Depends on tbw_pkg and the block itself; expected weights come from an area-ratio model held here.
module tb_triangle_barycentric_weights;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 100000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_PHASES = 10;
	localparam int POINTS_PER_PHASE = 75;
	localparam logic [tbw_pkg::WEIGHT_W-1:0] WEIGHT_SAT = '1;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_LONG} stall_mode_t;

	logic                                clk;
	logic                                arst_n;
	logic                                psel;
	logic                                penable;
	logic                                pwrite;
	logic [tbw_pkg::CFG_ADDR_W-1:0]      paddr;
	logic [tbw_pkg::CFG_DATA_W-1:0]      pwdata;
	logic [tbw_pkg::CFG_DATA_W-1:0]      prdata;
	logic                                pready;
	logic                                in_valid;
	logic                                in_stall;
	logic signed [tbw_pkg::FIELD_W-1:0]  point_x;
	logic signed [tbw_pkg::FIELD_W-1:0]  point_y;
	logic                                out_valid;
	logic                                out_stall;
	logic [tbw_pkg::WEIGHT_W-1:0]        weight_a;
	logic [tbw_pkg::WEIGHT_W-1:0]        weight_b;
	logic [tbw_pkg::WEIGHT_W-1:0]        weight_c;
	logic                                degenerate;

	logic signed [tbw_pkg::FIELD_W-1:0]  vertex [tbw_pkg::NUM_REGS];
	tbw_pkg::tbw_res_t                   weights_due [$];
	stall_mode_t                         stall_mode;
	int                                  cycle_count;
	int                                  stall_ctr;
	int                                  error_count;
	int                                  points_sent;
	int                                  results_seen;
	int                                  degen_seen;
	int                                  sat_seen;
	int                                  gap_pct;
	int                                  burst_left;

	triangle_barycentric_weights i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.point_x    (point_x),
		.point_y    (point_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.weight_a   (weight_a),
		.weight_b   (weight_b),
		.weight_c   (weight_c),
		.degenerate (degenerate)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint cross_mag(longint ux, longint uy, longint vx, longint vy);
		longint p;
		longint q;
		p = ux * vy;
		q = uy * vx;
		return (p >= q) ? p - q : q - p;
	endfunction

	function automatic logic [tbw_pkg::WEIGHT_W-1:0] area_ratio(longint num, longint den);
		longint scaled;
		if (num / den >= (longint'(1) << (tbw_pkg::WEIGHT_W - tbw_pkg::WEIGHT_FRAC_BITS_DEF)))
			return WEIGHT_SAT;
		scaled = (num <<< tbw_pkg::WEIGHT_FRAC_BITS_DEF) / den;
		return scaled[tbw_pkg::WEIGHT_W-1:0];
	endfunction

	function automatic tbw_pkg::tbw_res_t predict_weights(logic signed [tbw_pkg::FIELD_W-1:0] x,
			logic signed [tbw_pkg::FIELD_W-1:0] y);
		longint ax, ay, bx, by, cx, cy, px, py, total;
		tbw_pkg::tbw_res_t r;
		ax = vertex[tbw_pkg::REG_A_X];
		ay = vertex[tbw_pkg::REG_A_Y];
		bx = vertex[tbw_pkg::REG_B_X];
		by = vertex[tbw_pkg::REG_B_Y];
		cx = vertex[tbw_pkg::REG_C_X];
		cy = vertex[tbw_pkg::REG_C_Y];
		px = x;
		py = y;
		total = cross_mag(bx - ax, by - ay, cx - ax, cy - ay);
		r = '0;
		if (total == 0) begin
			r.degenerate = 1'b1;
		end else begin
			r.weight_a = area_ratio(cross_mag(bx - px, by - py, cx - px, cy - py), total);
			r.weight_b = area_ratio(cross_mag(ax - px, ay - py, cx - px, cy - py), total);
			r.weight_c = area_ratio(cross_mag(ax - px, ay - py, bx - px, by - py), total);
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch on %s at result %0d: got %h, expected %h",
			what, results_seen, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin : result_check
		tbw_pkg::tbw_res_t want;
		cycle_count++;
		if (arst_n && out_valid && !out_stall) begin
			if (weights_due.size() == 0) begin
				report_mismatch("unexpected item", {weight_a, 7'd0, degenerate}, 0);
			end else begin
				want = weights_due.pop_front();
				if (weight_a !== want.weight_a)
					report_mismatch("weight_a", weight_a, want.weight_a);
				if (weight_b !== want.weight_b)
					report_mismatch("weight_b", weight_b, want.weight_b);
				if (weight_c !== want.weight_c)
					report_mismatch("weight_c", weight_c, want.weight_c);
				if (degenerate !== want.degenerate)
					report_mismatch("degenerate", degenerate, want.degenerate);
				if (want.degenerate)
					degen_seen++;
				if (want.weight_a == WEIGHT_SAT || want.weight_b == WEIGHT_SAT ||
						want.weight_c == WEIGHT_SAT)
					sat_seen++;
			end
			results_seen++;
		end
		stall_ctr++;
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 40);
			default: out_stall <= ((stall_ctr % 64) >= 24);
		endcase
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAILURE");
		$finish;
	end

	task automatic write_vertex(tbw_pkg::tbw_reg_t idx, logic signed [tbw_pkg::FIELD_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		vertex[idx] = v;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_triangle(logic signed [tbw_pkg::FIELD_W-1:0] ax,
			logic signed [tbw_pkg::FIELD_W-1:0] ay,
			logic signed [tbw_pkg::FIELD_W-1:0] bx,
			logic signed [tbw_pkg::FIELD_W-1:0] by,
			logic signed [tbw_pkg::FIELD_W-1:0] cx,
			logic signed [tbw_pkg::FIELD_W-1:0] cy);
		write_vertex(tbw_pkg::REG_A_X, ax);
		write_vertex(tbw_pkg::REG_A_Y, ay);
		write_vertex(tbw_pkg::REG_B_X, bx);
		write_vertex(tbw_pkg::REG_B_Y, by);
		write_vertex(tbw_pkg::REG_C_X, cx);
		write_vertex(tbw_pkg::REG_C_Y, cy);
	endtask

	task automatic send_point(logic signed [tbw_pkg::FIELD_W-1:0] x,
			logic signed [tbw_pkg::FIELD_W-1:0] y);
		in_valid <= 1'b1;
		point_x  <= x;
		point_y  <= y;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		weights_due.push_back(predict_weights(x, y));
		points_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			if ($urandom_range(0, 99) < gap_pct) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	task automatic wait_weights_drained();
		in_valid <= 1'b0;
		while (weights_due.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic test_reset_vertices();
		stall_mode = STALL_NONE;
		gap_pct = 0;
		send_point(-16'sd32768, -16'sd32768);
		send_point(16'sd32767, 16'sd32767);
		send_point(16'sd0, 16'sd0);
		send_point(-16'sd1, 16'sd1);
		wait_weights_drained();
	endtask

	task automatic test_extreme_triangle();
		stall_mode = STALL_RANDOM;
		gap_pct = 30;
		set_triangle(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768,
			-16'sd32768, 16'sd32767);
		send_point(-16'sd32768, -16'sd32768);
		send_point(16'sd32767, -16'sd32768);
		send_point(-16'sd32768, 16'sd32767);
		send_point(16'sd0, 16'sd0);
		send_point(16'sd32767, 16'sd32767);
		send_point(-16'sd32768, 16'sd0);
		wait_weights_drained();
	endtask

	task automatic test_unit_triangle_saturation();
		stall_mode = STALL_LONG;
		gap_pct = 0;
		set_triangle(16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1);
		send_point(16'sd0, 16'sd0);
		send_point(16'sd255, 16'sd0);
		send_point(16'sd256, 16'sd0);
		send_point(16'sd32767, -16'sd32768);
		send_point(-16'sd32768, 16'sd32767);
		wait_weights_drained();
	endtask

	task automatic test_flat_and_reversed();
		stall_mode = STALL_RANDOM;
		gap_pct = 50;
		set_triangle(16'sd100, 16'sd100, 16'sd200, 16'sd200, -16'sd300, -16'sd300);
		send_point(16'sd7, -16'sd9);
		wait_weights_drained();
		set_triangle(16'sd5, 16'sd5, 16'sd5, 16'sd5, -16'sd40, 16'sd12);
		send_point(16'sd5, 16'sd5);
		wait_weights_drained();
		set_triangle(16'sd48, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd48);
		send_point(16'sd10, 16'sd7);
		send_point(-16'sd3, 16'sd50);
		wait_weights_drained();
	endtask

	task automatic test_random_triangles();
		logic signed [tbw_pkg::FIELD_W-1:0] tri_c [tbw_pkg::NUM_REGS];
		logic signed [tbw_pkg::FIELD_W-1:0] cx, cy, px, py;
		int radius, lo_x, hi_x, lo_y, hi_y;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			stall_mode = stall_mode_t'(phase % 3);
			gap_pct = (phase % 4) * 30;
			cx = tbw_pkg::FIELD_W'($urandom);
			cy = tbw_pkg::FIELD_W'($urandom);
			radius = 1 << $urandom_range(2, 12);
			for (int i = 0; i < tbw_pkg::NUM_REGS; i++) begin
				if (phase % 4 == 0)
					tri_c[i] = tbw_pkg::FIELD_W'($urandom);
				else
					tri_c[i] = ((i % 2) ? cy : cx)
						+ tbw_pkg::FIELD_W'($urandom_range(0, 2 * radius))
						- tbw_pkg::FIELD_W'(radius);
			end
			if (phase == 7) begin
				tri_c[tbw_pkg::REG_C_X] = tri_c[tbw_pkg::REG_A_X];
				tri_c[tbw_pkg::REG_C_Y] = tri_c[tbw_pkg::REG_A_Y];
			end
			set_triangle(tri_c[0], tri_c[1], tri_c[2], tri_c[3], tri_c[4], tri_c[5]);
			lo_x = vertex[tbw_pkg::REG_A_X];
			hi_x = lo_x;
			lo_y = vertex[tbw_pkg::REG_A_Y];
			hi_y = lo_y;
			foreach (vertex[i]) begin
				if (i % 2) begin
					if (vertex[i] < lo_y) lo_y = vertex[i];
					if (vertex[i] > hi_y) hi_y = vertex[i];
				end else begin
					if (vertex[i] < lo_x) lo_x = vertex[i];
					if (vertex[i] > hi_x) hi_x = vertex[i];
				end
			end
			for (int n = 0; n < POINTS_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) < 65) begin
					px = tbw_pkg::FIELD_W'(lo_x + $urandom_range(0, hi_x - lo_x));
					py = tbw_pkg::FIELD_W'(lo_y + $urandom_range(0, hi_y - lo_y));
				end else begin
					px = tbw_pkg::FIELD_W'($urandom);
					py = tbw_pkg::FIELD_W'($urandom);
				end
				send_point(px, py);
				if (phase == 4 && n == POINTS_PER_PHASE / 2)
					wait_weights_drained();
			end
			wait_weights_drained();
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		in_valid   = 1'b0;
		point_x    = '0;
		point_y    = '0;
		out_stall  = 1'b0;
		stall_mode = STALL_NONE;
		foreach (vertex[i]) vertex[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_vertices();
		test_extreme_triangle();
		test_unit_triangle_saturation();
		test_flat_and_reversed();
		test_random_triangles();

		wait_weights_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d points over %0d random triangles plus directed cases",
			points_sent, RANDOM_PHASES);
		$display("results checked: %0d, degenerate: %0d, with a saturated weight: %0d",
			results_seen, degen_seen, sat_seen);
		if (error_count == 0 && weights_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
